// ===== hw/rtl/dlrs_pkg.sv =====
// Shared types and constants for the display line refresh sequencer.
// Used by dlrs_line_store and display_line_refresh_sequencer_core; no dependencies.
package dlrs_pkg;

    // default geometry of the line store
    localparam int LINE_WIDTH_DEF = 128;
    localparam int NUM_LINES_DEF  = 8;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int PHASE_W = 3;
    localparam int MARK_W  = 8;
    localparam int CFG_W   = 4;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_START_COLUMN = 1'b0;
    localparam logic REG_LINES_IN_USE = 1'b1;
    localparam logic [CFG_W-1:0] START_COLUMN_RST = 4'd0;
    localparam logic [CFG_W-1:0] LINES_IN_USE_RST = 4'd8;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OP_W-1:0] OP_SERVICE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK_ALL = 2'd2;

    // byte kinds
    localparam logic [KIND_W-1:0] KIND_CMD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // refresh phases, counting down from column-low to release
    localparam logic [PHASE_W-1:0] PHASE_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_RELEASE  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_DATA_HI  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_DATA_LO  = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_PAGE     = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_COL_HIGH = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_COL_LOW  = 3'd6;
    localparam logic [PHASE_W-1:0] PHASE_SPARE    = 3'd7;

    // panel commands
    localparam logic [BYTE_W-1:0] CMD_COL_LOW  = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_PAGE     = 8'hB0;
    localparam logic [BYTE_W-1:0] RELEASE_BYTE = 8'h00;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT,
        ST_DATA
    } seq_state_t;

    // line store access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ls_ctrl_t;

endpackage

// ===== hw/rtl/dlrs_line_store.sv =====
// Line store memory: one write port, one registered read port, clearing sweep after reset.
// Depends on dlrs_pkg.
module dlrs_line_store #(
    parameter int NUM_LINES  = dlrs_pkg::NUM_LINES_DEF,
    parameter int LINE_WIDTH = dlrs_pkg::LINE_WIDTH_DEF,
    localparam int DEPTH     = NUM_LINES * LINE_WIDTH,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dlrs_pkg::ls_ctrl_t          ctrl,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [dlrs_pkg::BYTE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [dlrs_pkg::BYTE_W-1:0] rdata,
    output logic                        busy
);

    logic [dlrs_pkg::BYTE_W-1:0] line_mem [DEPTH];
    logic [dlrs_pkg::BYTE_W-1:0] rdata_reg;
    logic                        clearing_reg, clearing_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [dlrs_pkg::BYTE_W-1:0] mem_wdata;

    // sweep zeros through every entry before the sequencer starts
    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clearing_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_comb begin
        mem_we    = clearing_reg | ctrl.wr_en;
        mem_waddr = clearing_reg ? clr_addr_reg : waddr;
        mem_wdata = clearing_reg ? '0 : wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (ctrl.rd_en) begin
            rdata_reg <= line_mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

// ===== hw/rtl/display_line_refresh_sequencer_core.sv =====
// Dirty-line refresh sequencer: line store control, refresh phases and the panel byte stream.
// Depends on dlrs_pkg and dlrs_line_store.

// After reset the block clears all NUM_LINES*LINE_WIDTH entries (1024 by default) of its
// line store, one byte per cycle, and keeps s_ready low until the cycle after the sweep ends;
// configuration writes are taken meanwhile.
// A byte write, a mark-all and a scan step leave the sequencer idle and give no output word.
// A command or release step registers its byte, then loads it into the output register once it
// is free. A data step sets up its read address, then streams LINE_WIDTH/2 bytes (64 by default)
// from the line memory through its single read port, one byte per cycle while m_ready stays
// high; one item is worked on at a time, and a new item is taken while the last
// word still waits in the output register. Every output word is a command, a pixel data byte
// or a release marker, and m_last flags the final word of each service step.
module display_line_refresh_sequencer_core #(
    parameter int NUM_LINES  = dlrs_pkg::NUM_LINES_DEF,
    parameter int LINE_WIDTH = dlrs_pkg::LINE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dlrs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dlrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dlrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dlrs_pkg::OP_W-1:0]       s_operation,
    input  logic [dlrs_pkg::ROW_W-1:0]      s_row,
    input  logic [dlrs_pkg::COL_W-1:0]      s_column,
    input  logic [dlrs_pkg::BYTE_W-1:0]     s_value,
    input  logic                            s_burst_end,
    // output words
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dlrs_pkg::BYTE_W-1:0]     m_out_byte,
    output logic [dlrs_pkg::KIND_W-1:0]     m_byte_kind,
    output logic                            m_last
);

    localparam int DEPTH  = NUM_LINES * LINE_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int HALF   = LINE_WIDTH / 2;
    localparam int CNT_W  = $clog2(HALF + 1);

    dlrs_pkg::seq_state_t state_reg, state_next;

    logic [dlrs_pkg::CFG_W-1:0]   start_column_reg, lines_in_use_reg;
    logic [dlrs_pkg::MARK_W-1:0]  dirty_reg, dirty_next;
    logic [dlrs_pkg::ROW_W-1:0]   rp_reg, rp_next;
    logic [dlrs_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [dlrs_pkg::BYTE_W-1:0]  emit_byte_reg, emit_byte_next;
    logic [dlrs_pkg::KIND_W-1:0]  emit_kind_reg, emit_kind_next;
    logic [ADDR_W-1:0]            raddr_reg, raddr_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         rd_last_reg, rd_last_next;
    logic                         m_valid_reg, m_valid_next;
    logic [dlrs_pkg::BYTE_W-1:0]  m_out_byte_reg, m_out_byte_next;
    logic [dlrs_pkg::KIND_W-1:0]  m_byte_kind_reg, m_byte_kind_next;
    logic                         m_last_reg, m_last_next;

    logic                        cfg_wr;
    logic                        s_accept;
    logic [dlrs_pkg::CFG_W-1:0]  writable;
    logic [dlrs_pkg::CFG_W-1:0]  scanned;
    logic [dlrs_pkg::CFG_W-1:0]  rp_inc;
    logic [dlrs_pkg::ROW_W-1:0]  step_row;
    logic [dlrs_pkg::MARK_W-1:0] mark_mask;
    logic                        wr_ok;
    logic                        phase_idle, phase_emit, phase_data;
    logic                        out_free;
    logic                        move;
    logic                        ren;
    logic                        emit_load;
    logic                        data_done;
    logic [ADDR_W-1:0]           line_base;
    logic [ADDR_W-1:0]           waddr;
    logic                        ls_busy;
    logic [dlrs_pkg::BYTE_W-1:0] ls_rdata;
    dlrs_pkg::ls_ctrl_t          ls_ctrl;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_column_reg <= dlrs_pkg::START_COLUMN_RST;
            lines_in_use_reg <= dlrs_pkg::LINES_IN_USE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                dlrs_pkg::REG_START_COLUMN: start_column_reg <= pwdata[dlrs_pkg::CFG_W-1:0];
                dlrs_pkg::REG_LINES_IN_USE: lines_in_use_reg <= pwdata[dlrs_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dlrs_pkg::REG_START_COLUMN:
                prdata = dlrs_pkg::APB_DATA_W'(start_column_reg);
            dlrs_pkg::REG_LINES_IN_USE:
                prdata = dlrs_pkg::APB_DATA_W'(lines_in_use_reg);
            default: prdata = '0;
        endcase
    end

    // ---------------- item decode ----------------
    assign s_accept = s_valid & s_ready;

    always_comb begin
        writable = (lines_in_use_reg > dlrs_pkg::CFG_W'(NUM_LINES))
                 ? dlrs_pkg::CFG_W'(NUM_LINES) : lines_in_use_reg;
        scanned  = (writable == '0) ? dlrs_pkg::CFG_W'(1) : writable;
        rp_inc   = dlrs_pkg::CFG_W'(rp_reg) + 1'b1;
        step_row = (rp_inc >= scanned) ? '0 : rp_inc[dlrs_pkg::ROW_W-1:0];
        for (int i = 0; i < dlrs_pkg::MARK_W; i++) begin
            mark_mask[i] = (dlrs_pkg::CFG_W'(i) < writable);
        end
        wr_ok = (dlrs_pkg::CFG_W'(s_row) < writable)
              && ({1'b0, s_column} < 8'(LINE_WIDTH));
        phase_idle = (phase_reg == dlrs_pkg::PHASE_IDLE)
                   || (phase_reg == dlrs_pkg::PHASE_SPARE);
        phase_emit = (phase_reg == dlrs_pkg::PHASE_COL_LOW)
                   || (phase_reg == dlrs_pkg::PHASE_COL_HIGH)
                   || (phase_reg == dlrs_pkg::PHASE_PAGE)
                   || (phase_reg == dlrs_pkg::PHASE_RELEASE);
        phase_data = (phase_reg == dlrs_pkg::PHASE_DATA_LO)
                   || (phase_reg == dlrs_pkg::PHASE_DATA_HI);
        line_base  = ADDR_W'(int'(rp_reg) * LINE_WIDTH);
        waddr      = ADDR_W'(int'(s_row) * LINE_WIDTH + int'(s_column));
    end

    // ---------------- output staging ----------------
    assign out_free  = ~m_valid_reg | m_ready;
    assign move      = rd_valid_reg & out_free;
    assign data_done = (cnt_reg == CNT_W'(HALF)) & (~rd_valid_reg | move);

    // ---------------- state machine ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dlrs_pkg::ST_CLEAR: begin
                if (!ls_busy) state_next = dlrs_pkg::ST_IDLE;
            end
            dlrs_pkg::ST_IDLE: begin
                if (s_accept && s_operation == dlrs_pkg::OP_SERVICE) begin
                    if (phase_emit) state_next = dlrs_pkg::ST_EMIT;
                    else if (phase_data) state_next = dlrs_pkg::ST_DATA;
                end
            end
            dlrs_pkg::ST_EMIT: begin
                if (out_free) state_next = dlrs_pkg::ST_IDLE;
            end
            dlrs_pkg::ST_DATA: begin
                if (data_done) state_next = dlrs_pkg::ST_IDLE;
            end
            default: state_next = dlrs_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        emit_load = 1'b0;
        ren       = 1'b0;
        unique case (state_reg)
            dlrs_pkg::ST_CLEAR: ;
            dlrs_pkg::ST_IDLE:  s_ready = 1'b1;
            dlrs_pkg::ST_EMIT:  emit_load = out_free;
            dlrs_pkg::ST_DATA:
                ren = (cnt_reg != CNT_W'(HALF)) & (~rd_valid_reg | move);
            default: ;
        endcase
    end

    // ---------------- sequencer datapath ----------------
    always_comb begin
        dirty_next     = dirty_reg;
        rp_next        = rp_reg;
        phase_next     = phase_reg;
        emit_byte_next = emit_byte_reg;
        emit_kind_next = emit_kind_reg;
        raddr_next     = raddr_reg;
        cnt_next       = cnt_reg;
        if (s_accept) begin
            unique case (s_operation)
                dlrs_pkg::OP_WRITE: begin
                    if (wr_ok) dirty_next[s_row] = 1'b1;
                end
                dlrs_pkg::OP_MARK_ALL: dirty_next = dirty_reg | mark_mask;
                dlrs_pkg::OP_SERVICE: begin
                    case (phase_reg) inside
                        dlrs_pkg::PHASE_IDLE, dlrs_pkg::PHASE_SPARE: begin
                            // advance round-robin, start a run on a dirty line
                            rp_next = step_row;
                            if (dirty_reg[step_row]) begin
                                dirty_next[step_row] = 1'b0;
                                phase_next = dlrs_pkg::PHASE_COL_LOW;
                            end
                        end
                        dlrs_pkg::PHASE_COL_LOW: begin
                            emit_byte_next = dlrs_pkg::CMD_COL_LOW
                                           + dlrs_pkg::BYTE_W'(start_column_reg);
                            emit_kind_next = dlrs_pkg::KIND_CMD;
                        end
                        dlrs_pkg::PHASE_COL_HIGH: begin
                            emit_byte_next = dlrs_pkg::CMD_COL_HIGH;
                            emit_kind_next = dlrs_pkg::KIND_CMD;
                        end
                        dlrs_pkg::PHASE_PAGE: begin
                            emit_byte_next = dlrs_pkg::CMD_PAGE
                                           | dlrs_pkg::BYTE_W'(rp_reg);
                            emit_kind_next = dlrs_pkg::KIND_CMD;
                        end
                        dlrs_pkg::PHASE_DATA_LO: begin
                            raddr_next = line_base;
                            cnt_next   = '0;
                        end
                        dlrs_pkg::PHASE_DATA_HI: begin
                            raddr_next = line_base + ADDR_W'(HALF);
                            cnt_next   = '0;
                        end
                        dlrs_pkg::PHASE_RELEASE: begin
                            emit_byte_next = dlrs_pkg::RELEASE_BYTE;
                            emit_kind_next = dlrs_pkg::KIND_RELEASE;
                        end
                        default: ;
                    endcase
                    if (!phase_idle) phase_next = phase_reg - 1'b1;
                end
                default: ;
            endcase
        end
        if (ren) begin
            raddr_next = raddr_reg + 1'b1;
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    // read slot acts as the skid stage in front of the output register
    always_comb begin
        rd_valid_next = rd_valid_reg;
        rd_last_next  = rd_last_reg;
        if (ren) begin
            rd_valid_next = 1'b1;
            rd_last_next  = (cnt_reg == CNT_W'(HALF - 1));
        end else if (move) begin
            rd_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next     = m_valid_reg;
        m_out_byte_next  = m_out_byte_reg;
        m_byte_kind_next = m_byte_kind_reg;
        m_last_next      = m_last_reg;
        if (emit_load) begin
            m_valid_next     = 1'b1;
            m_out_byte_next  = emit_byte_reg;
            m_byte_kind_next = emit_kind_reg;
            m_last_next      = 1'b1;
        end else if (move) begin
            m_valid_next     = 1'b1;
            m_out_byte_next  = ls_rdata;
            m_byte_kind_next = dlrs_pkg::KIND_DATA;
            m_last_next      = rd_last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dlrs_pkg::ST_CLEAR;
            dirty_reg    <= '0;
            rp_reg       <= '0;
            phase_reg    <= dlrs_pkg::PHASE_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dirty_reg    <= dirty_next;
            rp_reg       <= rp_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        emit_byte_reg   <= emit_byte_next;
        emit_kind_reg   <= emit_kind_next;
        raddr_reg       <= raddr_next;
        rd_last_reg     <= rd_last_next;
        m_out_byte_reg  <= m_out_byte_next;
        m_byte_kind_reg <= m_byte_kind_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_byte_kind = m_byte_kind_reg;
    assign m_last      = m_last_reg;

    // ---------------- line store ----------------
    always_comb begin
        ls_ctrl.wr_en = s_accept & (s_operation == dlrs_pkg::OP_WRITE) & wr_ok;
        ls_ctrl.rd_en = ren;
    end

    dlrs_line_store #(
        .NUM_LINES  (NUM_LINES),
        .LINE_WIDTH (LINE_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ls_ctrl),
        .waddr   (waddr),
        .wdata   (s_value),
        .raddr   (raddr_reg),
        .rdata   (ls_rdata),
        .busy    (ls_busy)
    );

endmodule
